/* rtl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// K-way merge package
// Shared widths, codes, defaults and control structures of the merger.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // Default sizes of the merger
   localparam int WAYS_DEF       = 8;
   localparam int RUN_DEPTH_DEF  = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths of the channels and the control register
   localparam int ACTION_W = 2;
   localparam int WAY_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 4;

   localparam logic [CSR_W-1:0] ACTIVE_WAYS_RESET = 4'd8;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PULL  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;       // accept the request beat and act on it
      logic rd_issue;   // read the next head of the winning way
      logic head_load;  // load the read data into the head register
      logic out_load;   // move the result into the response register
   } kwm_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic pull_hit;   // the waiting request is a pull that finds a head
   } kwm_status_type;

endpackage

/* rtl/kwm_req_if.sv */
// ----------------------------------------------------------------------------
// K-way merge request channel
// Valid/ready channel that carries push, pull and clear requests.
// ----------------------------------------------------------------------------
interface kwm_req_if import kwm_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [WAY_W-1:0]    way;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output action, output way, output value, input ready);
   modport sink   (input valid, input action, input way, input value, output ready);

endinterface

/* rtl/kwm_rsp_if.sv */
// ----------------------------------------------------------------------------
// K-way merge response channel
// Valid/ready channel that carries one result beat per request.
// ----------------------------------------------------------------------------
interface kwm_rsp_if import kwm_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  merged_value;
   logic [WAY_W-1:0]    source_way;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output merged_value, output source_way, output status,
                   output last, input ready);
   modport sink   (input valid, input merged_value, input source_way, input status,
                   input last, output ready);

endinterface

/* rtl/kwm_ctrl.sv */
// ----------------------------------------------------------------------------
// K-way merge controller
// Sequences one request at a time and owns the response valid flag.
// ----------------------------------------------------------------------------
module kwm_ctrl import kwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  kwm_status_type status,
   output kwm_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Commands follow directly from the state and the handshakes.
   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == S_IDLE) && !reset && req_valid;
      cmd.rd_issue  = (state_ff == S_READ);
      cmd.head_load = (state_ff == S_WAIT);
      cmd.out_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // Next state: a pull that finds a head refills that head from memory.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = status.pull_hit ? S_READ : S_FINISH;
            end
         end
         S_READ:   state_in = S_WAIT;
         S_WAIT:   state_in = S_FINISH;
         S_FINISH: begin
            if (cmd.out_load) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // The response stays valid until the sink takes the beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/kwm_datapath.sv */
// ----------------------------------------------------------------------------
// K-way merge datapath
// Run store, per-way counts and head registers, minimum tree and result
// registers.
// ----------------------------------------------------------------------------
module kwm_datapath import kwm_pkg::*; #(
   parameter int WAYS       = WAYS_DEF,
   parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_W-1:0]    csr_wdata,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [WAY_W-1:0]    req_way,
   input  logic [VALUE_W-1:0]  req_value,
   output logic [VALUE_W-1:0]  rsp_merged_value,
   output logic [WAY_W-1:0]    rsp_source_way,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   input  kwm_cmd_type         cmd,
   output kwm_status_type      status
);

   localparam int WW    = $clog2(WAYS);
   localparam int LEAFS = 1 << WW;
   localparam int NODES = 2 * LEAFS - 1;
   localparam int IW    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CW    = $clog2(RUN_DEPTH + 1);
   localparam int LW    = $clog2(WAYS + 1);
   localparam int SW    = (WW > WAY_W) ? WW : WAY_W;
   localparam int EW    = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int AW    = WW + IW;
   localparam int MDEPTH = 1 << AW;

   logic [CSR_W-1:0]      active_ff;
   logic [CW-1:0]         fill_ff [WAYS];
   logic [CW-1:0]         read_ff [WAYS];
   logic [DATA_WIDTH-1:0] head_ff [WAYS];
   logic [DATA_WIDTH-1:0] mem [MDEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic [WW-1:0]         win_ff;
   logic [DATA_WIDTH-1:0] res_value_ff;
   logic [WW-1:0]         res_way_ff;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  res_hit_ff;

   logic [VALUE_W-1:0]    merged_ff;
   logic [WAY_W-1:0]      source_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic                  last_ff;

   logic [LW-1:0]         live;
   logic [WAYS-1:0]       head_valid;
   logic                  any_left;
   logic                  node_valid [NODES];
   logic [WW-1:0]         node_way   [NODES];
   logic [DATA_WIDTH-1:0] node_val   [NODES];
   logic [SW-1:0]         way_ext;
   logic [WW-1:0]         push_way;
   logic                  push_ok;
   logic                  push_empty;
   logic [EW-1:0]         in_ext;
   logic [EW-1:0]         out_ext;
   logic [SW-1:0]         src_ext;
   logic [AW-1:0]         rd_addr;
   logic                  pull_hit;

   // Active way count, clamped to one at the bottom and to WAYS at the top.
   always_comb begin
      if (active_ff == '0) begin
         live = LW'(1);
      end else if (32'(active_ff) > WAYS) begin
         live = LW'(WAYS);
      end else begin
         live = LW'(active_ff);
      end
   end

   // An active way holds a head while its read count trails its fill count.
   always_comb begin
      any_left = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         head_valid[w] = (w < int'(live)) && (read_ff[w] < fill_ff[w]);
         any_left      = any_left | head_valid[w];
      end
   end

   // Minimum tree over the heads; the left side wins ties, so the lower way wins.
   always_comb begin
      for (int n = 0; n < NODES; n++) begin
         node_valid[n] = 1'b0;
         node_way[n]   = '0;
         node_val[n]   = '0;
      end
      for (int w = 0; w < LEAFS; w++) begin
         if (w < WAYS) begin
            node_valid[LEAFS - 1 + w] = head_valid[w];
            node_val[LEAFS - 1 + w]   = head_ff[w];
         end
         node_way[LEAFS - 1 + w] = WW'(w);
      end
      for (int n = LEAFS - 2; n >= 0; n--) begin
         if (node_valid[2*n+1] &&
             (!node_valid[2*n+2] || node_val[2*n+1] <= node_val[2*n+2])) begin
            node_valid[n] = 1'b1;
            node_way[n]   = node_way[2*n+1];
            node_val[n]   = node_val[2*n+1];
         end else begin
            node_valid[n] = node_valid[2*n+2];
            node_way[n]   = node_way[2*n+2];
            node_val[n]   = node_val[2*n+2];
         end
      end
   end

   assign pull_hit        = (req_action == ACT_PULL) && node_valid[0];
   assign status.pull_hit = pull_hit;

   // Push decode: the way must exist and still have room.
   assign way_ext    = SW'(req_way);
   assign push_way   = way_ext[WW-1:0];
   assign push_ok    = (32'(req_way) < WAYS) && (fill_ff[push_way] != CW'(RUN_DEPTH));
   assign push_empty = (read_ff[push_way] == fill_ff[push_way]);
   assign in_ext     = EW'(req_value);
   assign rd_addr    = {win_ff, read_ff[win_ff][IW-1:0]};

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_WAYS_RESET;
      end else if (csr_we) begin
         active_ff <= csr_wdata;
      end
   end

   // Fill and read counts per way
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WAYS; w++) begin
            fill_ff[w] <= '0;
            read_ff[w] <= '0;
         end
      end else if (cmd.take) begin
         priority case (1'b1)
            (req_action == ACT_PUSH) && push_ok: begin
               fill_ff[push_way] <= fill_ff[push_way] + CW'(1);
            end
            pull_hit: begin
               read_ff[node_way[0]] <= read_ff[node_way[0]] + CW'(1);
            end
            (req_action == ACT_CLEAR): begin
               for (int w = 0; w < WAYS; w++) begin
                  fill_ff[w] <= '0;
                  read_ff[w] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Head registers: a push into an empty way sets the head at once,
   // otherwise a pull refills the head from the store.
   always_ff @(posedge clock) begin
      if (cmd.take && (req_action == ACT_PUSH) && push_ok && push_empty) begin
         head_ff[push_way] <= in_ext[DATA_WIDTH-1:0];
      end
      if (cmd.head_load) begin
         head_ff[win_ff] <= rdata_ff;
      end
   end

   // Run store, one region per way
   always_ff @(posedge clock) begin
      if (cmd.take && (req_action == ACT_PUSH) && push_ok) begin
         mem[{push_way, fill_ff[push_way][IW-1:0]}] <= in_ext[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Result staging when the request beat is taken
   always_comb begin
      res_status_in = ST_OK;
      if ((req_action == ACT_PUSH) && !push_ok) begin
         res_status_in = ST_DROP;
      end else if ((req_action == ACT_PULL) && !node_valid[0]) begin
         res_status_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         win_ff        <= node_way[0];
         res_value_ff  <= node_val[0];
         res_way_ff    <= node_way[0];
         res_status_ff <= res_status_in;
         res_hit_ff    <= pull_hit;
      end
   end

   // Response payload register
   assign out_ext = EW'(res_value_ff);
   assign src_ext = SW'(res_way_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         merged_ff <= res_hit_ff ? out_ext[VALUE_W-1:0] : '0;
         source_ff <= res_hit_ff ? src_ext[WAY_W-1:0] : '0;
         status_ff <= res_status_ff;
         last_ff   <= res_hit_ff && !any_left;
      end
   end

   assign rsp_merged_value = merged_ff;
   assign rsp_source_way   = source_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule

/* rtl/k_way_sorted_merge.sv */
// A push, clear or empty pull is staged when it is taken and then moved into the response
// register; a pull that finds a head first reads the winning way's next head from the run
// store into a read register and loads it into the head register. One request is worked on
// at a time. While a result beat waits, one more request is taken and then held in its last
// step until the response register is free.
// Reset clears all fill and read counts and sets active_ways to 8; the run store is not cleared.
// ----------------------------------------------------------------------------
// K-way sorted merge
// Merges up to WAYS sorted runs held in an on-chip store, one value per pull.
// ----------------------------------------------------------------------------
module k_way_sorted_merge import kwm_pkg::*; #(
   parameter int WAYS       = WAYS_DEF,
   parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   kwm_req_if.sink          req,
   kwm_rsp_if.source        rsp
);

   kwm_cmd_type    cmd;
   kwm_status_type status;

   // Sequencer
   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Store, heads and result path
   kwm_datapath #(
      .WAYS       (WAYS),
      .RUN_DEPTH  (RUN_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_action       (req.action),
      .req_way          (req.way),
      .req_value        (req.value),
      .rsp_merged_value (rsp.merged_value),
      .rsp_source_way   (rsp.source_way),
      .rsp_status       (rsp.status),
      .rsp_last         (rsp.last),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// K-way sorted merge testbench
// Drives push, pull and clear beats into the merger and checks every result
// beat against a behavioural merge model kept in the bench or, for a pinned
// row, against the row's own result. A short table of directed beats comes
// first, then merge jobs with random sorted runs under random active-way
// settings, then a job that fills one way to the brim. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   import kwm_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECT_ROWS   = 22;
   localparam int RANDOM_BEATS  = 730;
   localparam int MAX_RUN       = 6;

   // Action code that the block leaves unused
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam logic [VALUE_W-1:0]  VALUE_MAX = '1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [WAY_W-1:0]    way;
      logic [VALUE_W-1:0]  value;
   } merge_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  merged_value;
      logic [WAY_W-1:0]    source_way;
      logic [STATUS_W-1:0] status;
      logic                last;
   } merge_rsp_type;

   // One row of the directed table; a pinned row carries its own result.
   typedef struct packed {
      merge_req_type item;
      logic          pinned;
      merge_rsp_type outcome;
   } merge_row_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            csr_we;
   logic [CSR_W-1:0] csr_wdata;
   logic            pin_on;
   merge_rsp_type   pin_rsp;

   kwm_req_if req_if ();
   kwm_rsp_if rsp_if ();

   // Model state: run store, per-way counts and the active-way register
   logic [VALUE_W-1:0] run_mem [WAYS_DEF][RUN_DEPTH_DEF];
   int unsigned        run_fill [WAYS_DEF] = '{default: 0};
   int unsigned        run_read [WAYS_DEF] = '{default: 0};
   logic [CSR_W-1:0]   ways_cfg = ACTIVE_WAYS_RESET;

   merge_rsp_type merge_out_q [$];
   int            mismatch_count = 0;
   int            beats_sent = 0;
   int            cycle_count = 0;
   bit            calm = 1'b0;

   merge_row_type direct_rows [DIRECT_ROWS] = '{
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_EMPTY, 1'b0}},
      '{'{ACT_SPARE, 3'd7, 32'hFFFFFFFF}, 1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PUSH,  3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PUSH,  3'd7, 32'hFFFFFFFF}, 1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PUSH,  3'd3, 32'hFFFFFFFF}, 1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PUSH,  3'd1, 32'd5},        1'b0, '0},
      '{'{ACT_PUSH,  3'd1, 32'd3},        1'b0, '0},
      '{'{ACT_PUSH,  3'd2, 32'h0},        1'b0, '0},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PULL,  3'd5, 32'h0},        1'b1, '{32'h0,     3'd2, ST_OK,    1'b0}},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b0, '0},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b0, '0},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{VALUE_MAX, 3'd3, ST_OK,    1'b0}},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{VALUE_MAX, 3'd7, ST_OK,    1'b1}},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_EMPTY, 1'b0}},
      '{'{ACT_PUSH,  3'd4, 32'hA5A5A5A5}, 1'b0, '0},
      '{'{ACT_PUSH,  3'd5, 32'h5A5A5A5A}, 1'b0, '0},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b0, '0},
      '{'{ACT_CLEAR, 3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_OK,    1'b0}},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b1, '{32'h0,     3'd0, ST_EMPTY, 1'b0}},
      '{'{ACT_PUSH,  3'd6, 32'h13579BDF}, 1'b0, '0},
      '{'{ACT_PULL,  3'd0, 32'h0},        1'b0, '0}
   };

   k_way_sorted_merge i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_if),
      .rsp       (rsp_if)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Works out the result of one request beat and advances the model state.
   function automatic merge_rsp_type merge_step(merge_req_type item);
      merge_rsp_type r;
      int unsigned   live;
      int unsigned   pick;
      bit            found;
      bit            any_left;
      r        = '0;
      pick     = 0;
      found    = 1'b0;
      any_left = 1'b0;
      // Out-of-range settings fold back onto one way or onto every way.
      if (ways_cfg == 0) begin
         live = 1;
      end else if (ways_cfg > WAYS_DEF) begin
         live = WAYS_DEF;
      end else begin
         live = ways_cfg;
      end
      case (item.action)
         ACT_PUSH: begin
            if (run_fill[item.way] >= RUN_DEPTH_DEF) begin
               r.status = ST_DROP;
            end else begin
               run_mem[item.way][run_fill[item.way]] = item.value;
               run_fill[item.way]++;
            end
         end
         ACT_PULL: begin
            // Smallest head wins; a strict compare leaves ties with the lowest way.
            for (int w = 0; w < live; w++) begin
               if (run_read[w] < run_fill[w]) begin
                  if (!found || run_mem[w][run_read[w]] < r.merged_value) begin
                     r.merged_value = run_mem[w][run_read[w]];
                     pick           = w;
                     found          = 1'b1;
                  end
               end
            end
            if (!found) begin
               r.status = ST_EMPTY;
            end else begin
               run_read[pick]++;
               for (int w = 0; w < live; w++) begin
                  if (run_read[w] < run_fill[w]) any_left = 1'b1;
               end
               r.source_way = pick[WAY_W-1:0];
               r.last       = !any_left;
            end
         end
         ACT_CLEAR: begin
            for (int w = 0; w < WAYS_DEF; w++) begin
               run_fill[w] = 0;
               run_read[w] = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   // Watches both channels and the register port at every rising edge.
   always @(posedge clock) begin
      merge_rsp_type want;
      merge_rsp_type got;
      merge_rsp_type predicted;
      merge_req_type item;
      if (!reset) begin
         if (csr_we) ways_cfg = csr_wdata;
         if (req_if.valid && req_if.ready) begin
            item      = '{req_if.action, req_if.way, req_if.value};
            predicted = merge_step(item);
            merge_out_q.push_back(pin_on ? pin_rsp : predicted);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.merged_value, rsp_if.source_way, rsp_if.status, rsp_if.last};
            if (merge_out_q.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", got.merged_value, '0);
            end else begin
               want = merge_out_q.pop_front();
               if (got.merged_value !== want.merged_value)
                  report_mismatch("merged_value", got.merged_value, want.merged_value);
               if (got.source_way !== want.source_way)
                  report_mismatch("source_way", VALUE_W'(got.source_way),
                                  VALUE_W'(want.source_way));
               if (got.status !== want.status)
                  report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
               if (got.last !== want.last)
                  report_mismatch("last", VALUE_W'(got.last), VALUE_W'(want.last));
            end
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      if (calm) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Result side: after each beat, holds ready low for a drawn number of cycles.
   initial begin
      int unsigned hold;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            hold = draw_gap();
            if (hold != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (hold) @(posedge clock);
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // Offers one request beat after a drawn gap and returns once it is taken.
   task automatic send_beat(logic [ACTION_W-1:0] action, logic [WAY_W-1:0] way,
                            logic [VALUE_W-1:0] value, logic pinned = 1'b0,
                            merge_rsp_type outcome = '0);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.action <= action;
      req_if.way    <= way;
      req_if.value  <= value;
      pin_on        <= pinned;
      pin_rsp       <= outcome;
      do @(posedge clock); while (!req_if.ready);
      beats_sent++;
   endtask

   // Stops offering beats and waits until every result beat is back.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (merge_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ways(logic [CSR_W-1:0] count);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // An odd beat between the orderly ones: unused code, stray push, pull or clear.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0:       send_beat(ACT_SPARE, WAY_W'($urandom), $urandom);
         1:       send_beat(ACT_PUSH, WAY_W'($urandom), $urandom);
         2:       send_beat(ACT_PULL, WAY_W'($urandom), $urandom);
         default: send_beat(ACT_CLEAR, WAY_W'($urandom), $urandom);
      endcase
   endtask

   // One merge job: active-way write, clear, sorted runs pushed interleaved, then pulls that most often drain them.
   task automatic run_job(logic [CSR_W-1:0] count);
      logic [VALUE_W-1:0] runs [WAYS_DEF][MAX_RUN];
      int unsigned        run_len [WAYS_DEF];
      int unsigned        run_pos [WAYS_DEF];
      int unsigned        mode;
      int unsigned        total;
      int unsigned        pulls;
      int unsigned        w;
      logic [VALUE_W:0]   next;
      calm = ($urandom_range(0, 3) == 0);
      write_ways(count);
      send_beat(ACT_CLEAR, WAY_W'($urandom), $urandom);
      // Narrow values give many ties, wide ones exercise every bit, top ones the maximum.
      mode  = $urandom_range(0, 2);
      total = 0;
      for (int i = 0; i < WAYS_DEF; i++) begin
         case (mode)
            0:       next = $urandom_range(0, 3);
            1:       next = $urandom >> $urandom_range(0, 31);
            default: next = VALUE_MAX - $urandom_range(0, 6);
         endcase
         run_len[i] = $urandom_range(0, MAX_RUN);
         run_pos[i] = 0;
         for (int k = 0; k < run_len[i]; k++) begin
            runs[i][k] = next[VALUE_W-1:0];
            case (mode)
               0:       next = next + $urandom_range(0, 1);
               1:       next = next + ($urandom >> $urandom_range(3, 31));
               default: next = next + $urandom_range(0, 2);
            endcase
            if (next > VALUE_MAX) next = VALUE_MAX;
         end
         total += run_len[i];
      end
      pulls = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total)
                                          : total + $urandom_range(1, 3);
      while (total != 0) begin
         w = $urandom_range(0, WAYS_DEF - 1);
         if (run_pos[w] < run_len[w]) begin
            if ($urandom_range(0, 14) == 0) send_noise();
            send_beat(ACT_PUSH, WAY_W'(w), runs[w][run_pos[w]]);
            run_pos[w]++;
            total--;
         end
      end
      repeat (pulls) begin
         if ($urandom_range(0, 14) == 0) send_noise();
         send_beat(ACT_PULL, WAY_W'($urandom), $urandom);
      end
   endtask

   // Fills one way to its depth so that further pushes to it are dropped.
   task automatic fill_way();
      int unsigned      w;
      logic [VALUE_W:0] next;
      calm = ($urandom_range(0, 1) != 0);
      write_ways(CSR_W'($urandom_range(WAYS_DEF, 15)));
      send_beat(ACT_CLEAR, WAY_W'($urandom), $urandom);
      w    = $urandom_range(0, WAYS_DEF - 1);
      next = $urandom_range(0, 255);
      repeat (RUN_DEPTH_DEF) begin
         send_beat(ACT_PUSH, WAY_W'(w), next[VALUE_W-1:0]);
         next = next + $urandom_range(0, 1 << 22);
         if (next > VALUE_MAX) next = VALUE_MAX;
      end
      repeat (3) send_beat(ACT_PUSH, WAY_W'(w), $urandom);
      repeat (20) send_beat(ACT_PULL, WAY_W'($urandom), $urandom);
      send_beat(ACT_PUSH, WAY_W'(w), $urandom);
      send_beat(ACT_PUSH, WAY_W'(w + 1), $urandom);
      send_beat(ACT_PULL, WAY_W'($urandom), $urandom);
      send_beat(ACT_CLEAR, WAY_W'($urandom), $urandom);
      send_beat(ACT_PULL, WAY_W'($urandom), $urandom);
   endtask

   // Stimulus: reset, directed table, random merge jobs, then the full-way job.
   initial begin
      logic [CSR_W-1:0] corner_counts [5];
      int               job;
      corner_counts = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_wdata     <= ACTIVE_WAYS_RESET;
      req_if.valid  <= 1'b0;
      req_if.action <= ACT_PUSH;
      req_if.way    <= '0;
      req_if.value  <= '0;
      pin_on        <= 1'b0;
      pin_rsp       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (direct_rows[i]) begin
         send_beat(direct_rows[i].item.action, direct_rows[i].item.way,
                   direct_rows[i].item.value, direct_rows[i].pinned,
                   direct_rows[i].outcome);
      end

      job = 0;
      while (beats_sent < DIRECT_ROWS + RANDOM_BEATS) begin
         if (job < 5) begin
            run_job(corner_counts[job]);
         end else if ($urandom_range(0, 4) == 0) begin
            run_job(CSR_W'($urandom_range(0, 15)));
         end else begin
            run_job(CSR_W'($urandom_range(1, WAYS_DEF)));
         end
         job++;
      end

      fill_way();
      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
